// ----- design/cgm_pkg.sv -----
package cgm_pkg;

   localparam int POS_W      = 16;
   localparam int LEVELS_W   = 11;
   localparam int COUNT_W    = 3;
   localparam int STOP_W     = 40;
   localparam int CHAN_W     = 8;
   localparam int CHANNELS   = 3;
   localparam int STOP_REGS  = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int PROD_W     = POS_W + LEVELS_W;
   localparam int QUOT_STEPS = CHAN_W;

   localparam int MAX_STOPS_DEFAULT     = 6;
   localparam int FRACTION_BITS_DEFAULT = 15;

   localparam logic [CSR_ADDR_W-1:0] REG_LEVELS     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_STOP_COUNT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_STOP_ZERO  = 3'd2;

   localparam logic [LEVELS_W-1:0] LEVELS_RESET = 11'd200;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 3'd6;

   // position Q1.15 in 39..24, then red, green, blue
   localparam logic [STOP_W-1:0] STOP_RESET [STOP_REGS] = '{
      40'h0000800080,
      40'h199A0000FF,
      40'h333300FFFF,
      40'h4CCD00FF00,
      40'h6666FFFF00,
      40'h8000FF0000
   };

   typedef logic [CHAN_W-1:0] chan_type;
   typedef chan_type [CHANNELS-1:0] rgb_type;   // [0] red, [1] green, [2] blue

   typedef struct packed {
      logic    found;
      rgb_type lo_rgb;
      rgb_type hi_rgb;
   } seg_type;

   function automatic int scaled_width(input int fraction_bits);
      return (PROD_W > LEVELS_W + fraction_bits) ? PROD_W : LEVELS_W + fraction_bits;
   endfunction

   function automatic logic [POS_W-1:0] stop_position(input logic [STOP_W-1:0] stop);
      return stop[STOP_W-1 -: POS_W];
   endfunction

   function automatic rgb_type stop_rgb(input logic [STOP_W-1:0] stop);
      rgb_type rgb;
      for (int c = 0; c < CHANNELS; c++) begin
         rgb[c] = stop[(CHANNELS-1-c)*CHAN_W +: CHAN_W];
      end
      return rgb;
   endfunction

endpackage

// ----- design/cgm_csr.sv -----
module cgm_csr
   import cgm_pkg::*;
#(
   parameter int MAX_STOPS     = MAX_STOPS_DEFAULT,
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   localparam int SCALED_W     = scaled_width(FRACTION_BITS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [STOP_W-1:0]     csr_wdata,
   output logic [LEVELS_W-1:0]   lv,
   output logic [COUNT_W-1:0]    n_eff,
   output logic [SCALED_W-1:0]   stop_scaled [MAX_STOPS],
   output rgb_type               stop_color [MAX_STOPS]
);

   logic [LEVELS_W-1:0] levels_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [STOP_W-1:0]   stop_ff [MAX_STOPS];
   logic [SCALED_W-1:0] scaled_ff [MAX_STOPS];
   logic [SCALED_W-1:0] scaled_in [MAX_STOPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
         count_ff  <= COUNT_RESET;
         for (int i = 0; i < MAX_STOPS; i++) begin
            stop_ff[i] <= STOP_RESET[i];
         end
      end else if (csr_we) begin
         case (csr_addr)
            REG_LEVELS: begin
               levels_ff <= csr_wdata[LEVELS_W-1:0];
            end
            REG_STOP_COUNT: begin
               count_ff <= csr_wdata[COUNT_W-1:0];
            end
            default: begin
               for (int i = 0; i < MAX_STOPS; i++) begin
                  if (csr_addr == REG_STOP_ZERO + CSR_ADDR_W'(i)) begin
                     stop_ff[i] <= csr_wdata;
                  end
               end
            end
         endcase
      end
   end

   assign lv    = (levels_ff == '0) ? LEVELS_W'(1) : levels_ff;
   assign n_eff = (count_ff > COUNT_W'(MAX_STOPS)) ? COUNT_W'(MAX_STOPS) : count_ff;

   // stop positions pre-scaled by the level count
   for (genvar i = 0; i < MAX_STOPS; i++) begin : g_stop
      logic [PROD_W-1:0] prod;
      assign prod         = PROD_W'(stop_position(stop_ff[i])) * PROD_W'(lv);
      assign scaled_in[i] = SCALED_W'(prod);

      always_ff @(posedge clock) begin
         scaled_ff[i] <= scaled_in[i];
      end

      assign stop_scaled[i] = scaled_ff[i];
      assign stop_color[i]  = stop_rgb(stop_ff[i]);
   end

endmodule

// ----- design/cgm_locate.sv -----
module cgm_locate
   import cgm_pkg::*;
#(
   parameter int MAX_STOPS     = MAX_STOPS_DEFAULT,
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   localparam int SCALED_W     = scaled_width(FRACTION_BITS),
   localparam int IDX_W        = $clog2(MAX_STOPS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [POS_W-1:0]    in_position,
   input  logic [LEVELS_W-1:0] lv,
   input  logic [COUNT_W-1:0]  n_eff,
   input  logic [SCALED_W-1:0] stop_scaled [MAX_STOPS],
   input  rgb_type             stop_color [MAX_STOPS],
   output logic                out_valid,
   output seg_type             out_seg,
   output logic [SCALED_W-1:0] out_d1,
   output logic [SCALED_W-1:0] out_d2,
   output logic [SCALED_W-1:0] out_dt
);

   logic                v_a_ff, v_b_ff, v_c_ff, v_d_ff;
   logic [POS_W-1:0]    pos_a_ff;
   logic [PROD_W-1:0]   prod_b_ff;
   logic [PROD_W-1:0]   prod_in;
   logic [SCALED_W-1:0] point_c_ff;
   logic [IDX_W-1:0]    idx_c_ff;
   logic                found_c_ff;
   seg_type             seg_d_ff;
   logic [SCALED_W-1:0] d1_d_ff, d2_d_ff, dt_d_ff;

   logic [PROD_W-1:0]   lvl_raw;
   logic [LEVELS_W-1:0] lv_m1;
   logic [LEVELS_W-1:0] level;
   logic [SCALED_W-1:0] point_in;
   logic [MAX_STOPS-1:0] hit;
   logic [IDX_W-1:0]    idx_in;

   logic [IDX_W-1:0]    prev_idx;
   logic [SCALED_W-1:0] hi, lo_raw, lo;
   seg_type             seg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
      end else if (en) begin
         v_a_ff <= in_valid;
         v_b_ff <= v_a_ff;
         v_c_ff <= v_b_ff;
         v_d_ff <= v_c_ff;
      end
   end

   // stage a: position times level count
   assign prod_in = PROD_W'(pos_a_ff) * PROD_W'(lv);

   // stage b: clamp level, compare against scaled stops
   assign lvl_raw  = prod_b_ff >> FRACTION_BITS;
   assign lv_m1    = lv - LEVELS_W'(1);
   assign level    = (lvl_raw > PROD_W'(lv_m1)) ? lv_m1 : lvl_raw[LEVELS_W-1:0];
   assign point_in = SCALED_W'(level) << FRACTION_BITS;

   for (genvar i = 0; i < MAX_STOPS; i++) begin : g_hit
      assign hit[i] = (COUNT_W'(i) < n_eff) && (stop_scaled[i] > point_in);
   end

   always_comb begin
      idx_in = '0;
      for (int i = MAX_STOPS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            idx_in = IDX_W'(i);
         end
      end
   end

   // stage c: segment ends and distances
   always_comb begin
      prev_idx      = (idx_c_ff == '0) ? '0 : idx_c_ff - IDX_W'(1);
      hi            = stop_scaled[idx_c_ff];
      lo_raw        = (idx_c_ff == '0) ? '0 : stop_scaled[prev_idx];
      lo            = (lo_raw > point_c_ff) ? point_c_ff : lo_raw;
      seg_in.found  = found_c_ff;
      seg_in.lo_rgb = stop_color[prev_idx];
      seg_in.hi_rgb = stop_color[idx_c_ff];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_a_ff   <= in_position;
         prod_b_ff  <= prod_in;
         point_c_ff <= point_in;
         idx_c_ff   <= idx_in;
         found_c_ff <= |hit;
         seg_d_ff   <= seg_in;
         d1_d_ff    <= point_c_ff - lo;
         d2_d_ff    <= hi - point_c_ff;
         dt_d_ff    <= hi - lo;
      end
   end

   assign out_valid = v_d_ff;
   assign out_seg   = seg_d_ff;
   assign out_d1    = d1_d_ff;
   assign out_d2    = d2_d_ff;
   assign out_dt    = dt_d_ff;

endmodule

// ----- design/cgm_blend.sv -----
module cgm_blend
   import cgm_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   localparam int SCALED_W     = scaled_width(FRACTION_BITS),
   localparam int NUM_W        = SCALED_W + CHAN_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  seg_type             in_seg,
   input  logic [SCALED_W-1:0] in_d1,
   input  logic [SCALED_W-1:0] in_d2,
   input  logic [SCALED_W-1:0] in_dt,
   output logic                out_valid,
   output logic                out_found,
   output logic [NUM_W-1:0]    out_num [CHANNELS],
   output logic [SCALED_W-1:0] out_dt
);

   logic                v_e_ff, v_f_ff;
   logic                found_e_ff, found_f_ff;
   logic [SCALED_W-1:0] dt_e_ff, dt_f_ff;
   logic [NUM_W-1:0]    p_lo_ff [CHANNELS];
   logic [NUM_W-1:0]    p_hi_ff [CHANNELS];
   logic [NUM_W-1:0]    num_ff  [CHANNELS];
   logic [NUM_W-1:0]    p_lo_in [CHANNELS];
   logic [NUM_W-1:0]    p_hi_in [CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_e_ff <= 1'b0;
         v_f_ff <= 1'b0;
      end else if (en) begin
         v_e_ff <= in_valid;
         v_f_ff <= v_e_ff;
      end
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      assign p_lo_in[c] = NUM_W'(in_seg.lo_rgb[c]) * NUM_W'(in_d2);
      assign p_hi_in[c] = NUM_W'(in_seg.hi_rgb[c]) * NUM_W'(in_d1);

      // sum stays below 256 * dt
      always_ff @(posedge clock) begin
         if (en) begin
            p_lo_ff[c] <= p_lo_in[c];
            p_hi_ff[c] <= p_hi_in[c];
            num_ff[c]  <= p_lo_ff[c] + p_hi_ff[c];
         end
      end

      assign out_num[c] = num_ff[c];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         found_e_ff <= in_seg.found;
         found_f_ff <= found_e_ff;
         dt_e_ff    <= in_dt;
         dt_f_ff    <= dt_e_ff;
      end
   end

   assign out_valid = v_f_ff;
   assign out_found = found_f_ff;
   assign out_dt    = dt_f_ff;

endmodule

// ----- design/cgm_div.sv -----
module cgm_div
   import cgm_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   localparam int SCALED_W     = scaled_width(FRACTION_BITS),
   localparam int NUM_W        = SCALED_W + CHAN_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic                in_found,
   input  logic [NUM_W-1:0]    in_num [CHANNELS],
   input  logic [SCALED_W-1:0] in_dt,
   output logic                out_valid,
   output rgb_type             out_rgb,
   output logic                out_beyond
);

   // restoring division, one quotient bit per stage, msb first
   logic                v_ff     [QUOT_STEPS];
   logic                found_ff [QUOT_STEPS];
   logic [SCALED_W-1:0] dt_ff    [QUOT_STEPS];
   logic [NUM_W-1:0]    rem_ff   [QUOT_STEPS][CHANNELS];
   rgb_type             q_ff     [QUOT_STEPS];

   logic                stg_v     [QUOT_STEPS+1];
   logic                stg_found [QUOT_STEPS+1];
   logic [SCALED_W-1:0] stg_dt    [QUOT_STEPS+1];
   logic [NUM_W-1:0]    stg_rem   [QUOT_STEPS+1][CHANNELS];
   rgb_type             stg_q     [QUOT_STEPS+1];

   logic [NUM_W-1:0]    rem_in    [QUOT_STEPS][CHANNELS];
   rgb_type             q_in      [QUOT_STEPS];

   assign stg_v[0]     = in_valid;
   assign stg_found[0] = in_found;
   assign stg_dt[0]    = in_dt;
   assign stg_q[0]     = '0;
   for (genvar c = 0; c < CHANNELS; c++) begin : g_head
      assign stg_rem[0][c] = in_num[c];
   end

   for (genvar s = 0; s < QUOT_STEPS; s++) begin : g_step
      localparam int BIT = QUOT_STEPS - 1 - s;
      logic [NUM_W-1:0] divisor;

      assign divisor = NUM_W'(stg_dt[s]) << BIT;

      always_comb begin
         q_in[s] = stg_q[s];
         for (int c = 0; c < CHANNELS; c++) begin
            if (stg_rem[s][c] >= divisor) begin
               rem_in[s][c]   = stg_rem[s][c] - divisor;
               q_in[s][c][BIT] = 1'b1;
            end else begin
               rem_in[s][c] = stg_rem[s][c];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= stg_v[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            found_ff[s] <= stg_found[s];
            dt_ff[s]    <= stg_dt[s];
            q_ff[s]     <= q_in[s];
            for (int c = 0; c < CHANNELS; c++) begin
               rem_ff[s][c] <= rem_in[s][c];
            end
         end
      end

      assign stg_v[s+1]     = v_ff[s];
      assign stg_found[s+1] = found_ff[s];
      assign stg_dt[s+1]    = dt_ff[s];
      assign stg_q[s+1]     = q_ff[s];
      for (genvar c = 0; c < CHANNELS; c++) begin : g_rem
         assign stg_rem[s+1][c] = rem_ff[s][c];
      end
   end

   assign out_valid  = stg_v[QUOT_STEPS];
   assign out_beyond = !stg_found[QUOT_STEPS];
   assign out_rgb    = stg_found[QUOT_STEPS] ? stg_q[QUOT_STEPS] : '0;

endmodule

// ----- design/color_gradient_map_top.sv -----
// Piecewise linear color gradient: each request carries a Q1.15 position, which is
// quantized to one of csr levels, placed between the two surrounding color stops and
// blended per channel with truncation; points at or past the last active stop give
// black with rsp_beyond_last_stop set. The block takes one request per clock unless
// rsp_ready stalls it; stages a to d locate the segment, e and f form the weighted
// sums, and an eight-stage restoring divider yields one quotient bit per stage. A
// response held by rsp_ready low stalls the whole pipeline in place. The user must
// write stop registers only while no request is in flight; the block does not enforce it.
module color_gradient_map_top
   import cgm_pkg::*;
#(
   parameter int MAX_STOPS     = MAX_STOPS_DEFAULT,
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [POS_W-1:0]      req_position,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAN_W-1:0]     rsp_red,
   output logic [CHAN_W-1:0]     rsp_green,
   output logic [CHAN_W-1:0]     rsp_blue,
   output logic                  rsp_beyond_last_stop,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [STOP_W-1:0]     csr_wdata
);

   localparam int SCALED_W = scaled_width(FRACTION_BITS);
   localparam int NUM_W    = SCALED_W + CHAN_W;

   logic                en;
   logic [LEVELS_W-1:0] lv;
   logic [COUNT_W-1:0]  n_eff;
   logic [SCALED_W-1:0] stop_scaled [MAX_STOPS];
   rgb_type             stop_color [MAX_STOPS];

   logic                loc_valid;
   seg_type             loc_seg;
   logic [SCALED_W-1:0] loc_d1, loc_d2, loc_dt;

   logic                bl_valid, bl_found;
   logic [NUM_W-1:0]    bl_num [CHANNELS];
   logic [SCALED_W-1:0] bl_dt;

   rgb_type             rgb;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en && !reset;

   cgm_csr #(
      .MAX_STOPS     (MAX_STOPS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .lv          (lv),
      .n_eff       (n_eff),
      .stop_scaled (stop_scaled),
      .stop_color  (stop_color)
   );

   cgm_locate #(
      .MAX_STOPS     (MAX_STOPS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_locate (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid && req_ready),
      .in_position (req_position),
      .lv          (lv),
      .n_eff       (n_eff),
      .stop_scaled (stop_scaled),
      .stop_color  (stop_color),
      .out_valid   (loc_valid),
      .out_seg     (loc_seg),
      .out_d1      (loc_d1),
      .out_d2      (loc_d2),
      .out_dt      (loc_dt)
   );

   cgm_blend #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (loc_valid),
      .in_seg    (loc_seg),
      .in_d1     (loc_d1),
      .in_d2     (loc_d2),
      .in_dt     (loc_dt),
      .out_valid (bl_valid),
      .out_found (bl_found),
      .out_num   (bl_num),
      .out_dt    (bl_dt)
   );

   cgm_div #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (bl_valid),
      .in_found   (bl_found),
      .in_num     (bl_num),
      .in_dt      (bl_dt),
      .out_valid  (rsp_valid),
      .out_rgb    (rgb),
      .out_beyond (rsp_beyond_last_stop)
   );

   assign rsp_red   = rgb[0];
   assign rsp_green = rgb[1];
   assign rsp_blue  = rgb[2];

endmodule
